// ----- rtl/vhc_pkg.sv -----
`default_nettype none
package vhc_pkg;
    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int TAG_BITS = 64;
    localparam int ENT_W = 3 * TAG_BITS + 64;
    localparam logic [63:0] FINAL_STAMP = '1;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] root;
        logic [TAG_BITS-1:0] block;
        logic [TAG_BITS-1:0] voter;
        logic [63:0] stamp;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic wr_new;
        logic clr_keep;
        logic check;
    } cmd_t;

    typedef struct packed {
        logic is_root;
        logic drop_add;
        logic same_keep;
        logic lookup_hit;
        kind_t kind;
    } stat_t;
endpackage
`default_nettype wire

// ----- rtl/vhc_ram.sv -----
`default_nettype none
module vhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/vhc_datapath.sv -----
`default_nettype none
module vhc_datapath (
    input  wire logic                  aclk,
    input  wire vhc_pkg::cmd_t         cmd,
    input  wire logic [1:0]            s_kind,
    input  wire logic [63:0]           s_root_tag,
    input  wire logic [63:0]           s_block_tag,
    input  wire logic [63:0]           s_voter,
    input  wire logic [63:0]           s_stamp,
    input  wire logic                  s_match_block,
    input  wire logic                  s_final_only,
    output vhc_pkg::stat_t             stat,
    output logic                       keep_new,
    output logic [63:0]                rd_voter,
    output logic [63:0]                rd_stamp
);
    import vhc_pkg::*;

    entry_t op_reg;
    kind_t kind_reg;
    logic mb_reg, fo_reg, keep_reg;
    entry_t rd_ent, wr_ent;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg.root <= s_root_tag[TAG_BITS-1:0];
            op_reg.block <= s_block_tag[TAG_BITS-1:0];
            op_reg.voter <= s_voter[TAG_BITS-1:0];
            op_reg.stamp <= s_stamp;
            kind_reg <= kind_t'(s_kind);
            mb_reg <= s_match_block;
            fo_reg <= s_final_only;
        end
        if (cmd.clr_keep) begin
            keep_reg <= 1'b1;
        end else if (cmd.check && stat.same_keep) begin
            keep_reg <= 1'b0;
        end
    end

    assign wr_ent = cmd.wr_new ? op_reg : rd_ent;

    vhc_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
        .aclk(aclk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_ent),
        .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_ent)
    );

    logic same_root, same_voter;
    assign same_root = rd_ent.root == op_reg.root;
    assign same_voter = rd_ent.voter == op_reg.voter;
    always_comb begin
        stat.kind = kind_reg;
        stat.is_root = same_root;
        stat.drop_add = same_root && (rd_ent.block != op_reg.block
            || (same_voter && rd_ent.stamp <= op_reg.stamp));
        stat.same_keep = same_root && !stat.drop_add && same_voter
            && kind_reg == KIND_ADD;
        stat.lookup_hit = same_root && (!mb_reg || (rd_ent.block == op_reg.block
            && (!fo_reg || rd_ent.stamp == FINAL_STAMP)));
    end
    assign keep_new = keep_reg;
    assign rd_voter = rd_ent.voter;
    assign rd_stamp = rd_ent.stamp;
endmodule
`default_nettype wire

// ----- rtl/vhc_ctrl.sv -----
`default_nettype none
module vhc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [5:0]     cfg_data,
    output vhc_pkg::cmd_t       cmd,
    input  wire vhc_pkg::stat_t stat,
    input  wire logic           keep_new,
    input  wire logic [63:0]    rd_voter,
    input  wire logic [63:0]    rd_stamp,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_found,
    output logic [63:0]         m_out_voter,
    output logic [63:0]         m_out_stamp,
    output logic                m_stored,
    output logic [6:0]          m_occupancy,
    output logic                m_last
);
    import vhc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EVICT, ST_READ, ST_CHECK, ST_FINISH, ST_HOLD
    } state_t;

    state_t state_reg;
    logic [5:0] limit_reg;
    logic [CNT_W-1:0] count_reg, rd_reg, wr_reg;
    logic pend_reg;
    logic [63:0] pv_reg, ps_reg;
    logic [CNT_W-1:0] lim;
    logic drop;
    logic out_free;
    logic out_load;
    logic hit_emit;

    assign cfg_ready = 1'b1;
    assign s_ready = state_reg == ST_IDLE && !m_valid;
    assign lim = (CNT_W'(limit_reg) > CNT_W'(SLOTS - 1)) ? CNT_W'(SLOTS - 1)
                                                         : CNT_W'(limit_reg);
    assign out_free = !m_valid || m_ready;
    assign hit_emit = state_reg == ST_CHECK && stat.kind == KIND_LOOKUP
                      && stat.lookup_hit && pend_reg;
    assign out_load = (hit_emit || state_reg == ST_FINISH) && out_free;

    always_comb begin
        unique case (stat.kind)
            KIND_ADD: drop = stat.drop_add;
            KIND_ERASE: drop = stat.is_root;
            default: drop = 1'b0;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.load = s_valid && s_ready;
        cmd.clr_keep = cmd.load;
        cmd.check = state_reg == ST_CHECK;
        cmd.rd_en = state_reg == ST_READ;
        cmd.rd_addr = rd_reg[IDX_W-1:0];
        if (state_reg == ST_CHECK && !drop
            && (stat.kind == KIND_ADD || stat.kind == KIND_ERASE)) begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = wr_reg[IDX_W-1:0];
        end
        if (state_reg == ST_FINISH && stat.kind == KIND_ADD && keep_new) begin
            cmd.wr_en = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.wr_addr = wr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            limit_reg <= 6'd63;
            count_reg <= '0;
            m_valid <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (m_valid && m_ready && !out_load) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.load) begin
                        state_reg <= ST_EVICT;
                        pend_reg <= 1'b0;
                    end
                end
                ST_EVICT: begin
                    if (stat.kind == KIND_ADD && count_reg > lim) begin
                        rd_reg <= count_reg - lim;
                    end else begin
                        rd_reg <= '0;
                    end
                    wr_reg <= '0;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    if (rd_reg >= count_reg) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (!(hit_emit && !out_free)) begin
                        rd_reg <= rd_reg + 1'b1;
                        if (!drop) begin
                            wr_reg <= wr_reg + 1'b1;
                        end
                        state_reg <= ST_READ;
                        if (stat.kind == KIND_LOOKUP && stat.lookup_hit) begin
                            if (pend_reg) begin
                                m_valid <= 1'b1;
                                m_found <= 1'b1;
                                m_out_voter <= pv_reg;
                                m_out_stamp <= ps_reg;
                                m_stored <= 1'b0;
                                m_occupancy <= 7'(count_reg);
                                m_last <= 1'b0;
                            end
                            pend_reg <= 1'b1;
                            pv_reg <= rd_voter;
                            ps_reg <= rd_stamp;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        logic [CNT_W-1:0] nc;
                        nc = wr_reg;
                        if (stat.kind == KIND_ADD && keep_new) begin
                            nc = wr_reg + 1'b1;
                        end
                        if (stat.kind == KIND_ADD || stat.kind == KIND_ERASE) begin
                            count_reg <= nc;
                        end
                        m_valid <= 1'b1;
                        m_found <= pend_reg;
                        m_out_voter <= pend_reg ? pv_reg : 64'd0;
                        m_out_stamp <= pend_reg ? ps_reg : 64'd0;
                        m_stored <= stat.kind == KIND_ADD && keep_new;
                        m_occupancy <= (stat.kind == KIND_ADD || stat.kind == KIND_ERASE)
                                       ? 7'(nc) : 7'(count_reg);
                        m_last <= 1'b1;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/vote_history_cache_top.sv -----
`default_nettype none
// Vote history cache: a store of up to 64 votes held oldest first.
// One command beat enters on the s_ channel: add, erase or lookup by root.
// Add and erase answer with one result beat; a lookup answers with one beat
// per matching vote, oldest first, or with a single empty beat when none
// matches. The final beat of each command carries m_last.
// Every command walks the stored entries through one RAM read port,
// reading and then checking each; the next command is taken only after
// the last beat is taken. The cache_limit register is written on the cfg_
// channel, by the user only while idle; the block does not enforce it.
// Reset empties the store and sets the limit to 63; no clearing pass is
// needed because only entries below the occupancy are ever read.
// When the receiver stalls, the walk waits on the output register and
// resumes once the pending beat is taken; no beat is lost.
module vote_history_cache_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [63:0] s_root_tag,
    input  wire logic [63:0] s_block_tag,
    input  wire logic [63:0] s_voter,
    input  wire logic [63:0] s_stamp,
    input  wire logic        s_match_block,
    input  wire logic        s_final_only,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [63:0]      m_out_voter,
    output logic [63:0]      m_out_stamp,
    output logic             m_stored,
    output logic [6:0]       m_occupancy,
    output logic             m_last
);
    import vhc_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic keep_new;
    logic [63:0] rd_voter, rd_stamp;

    vhc_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .s_kind(s_kind), .s_root_tag(s_root_tag),
        .s_block_tag(s_block_tag), .s_voter(s_voter), .s_stamp(s_stamp),
        .s_match_block(s_match_block), .s_final_only(s_final_only),
        .stat(stat), .keep_new(keep_new), .rd_voter(rd_voter), .rd_stamp(rd_stamp)
    );

    vhc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat), .keep_new(keep_new), .rd_voter(rd_voter),
        .rd_stamp(rd_stamp), .m_valid(m_valid), .m_ready(m_ready),
        .m_found(m_found), .m_out_voter(m_out_voter), .m_out_stamp(m_out_stamp),
        .m_stored(m_stored), .m_occupancy(m_occupancy), .m_last(m_last)
    );
endmodule
`default_nettype wire

// ----- rtl/vhc_checker.sv -----
`default_nettype none
module vhc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_found,
    input wire logic       m_stored,
    input wire logic [6:0] m_occupancy
);
    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_occupancy <= 7'd64) else $error("occupancy out of range");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_stored)) else $error("found and stored together");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted two commands");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule

bind vote_history_cache_top vhc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
    .m_stored(m_stored), .m_occupancy(m_occupancy)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
    logic        found;
    logic [63:0] voter;
    logic [63:0] stamp;
    logic        stored;
    logic [6:0]  occupancy;
    logic        last;
} vote_beat_t;

class vote_scoreboard;
    vhc_pkg::entry_t store [$];
    int unsigned     limit;
    vote_beat_t      pending [$];
    int unsigned     mismatches;

    function new();
        limit = 63;
        mismatches = 0;
    endfunction

    function void set_limit(logic [5:0] v);
        limit = v;
    endfunction

    function void push_beat(logic f, logic [63:0] v, logic [63:0] s, logic st, logic l);
        vote_beat_t b;
        b.found = f;
        b.voter = v;
        b.stamp = s;
        b.stored = st;
        b.occupancy = 7'(store.size());
        b.last = l;
        pending.push_back(b);
    endfunction

    function void note_command(vhc_pkg::kind_t kind, logic [63:0] root, logic [63:0] blk,
                               logic [63:0] voter, logic [63:0] stamp, logic mb, logic fo);
        int unsigned     lim;
        bit              keep_new;
        int              i;
        int              n;
        bit              hit;
        vhc_pkg::entry_t e;
        case (kind)
            vhc_pkg::KIND_ADD: begin
                lim = (limit > 63) ? 63 : limit;
                keep_new = 1;
                while (store.size() > lim) store.pop_front();
                i = 0;
                while (i < store.size()) begin
                    if (store[i].root != root) begin
                        i++;
                    end else if (store[i].block != blk ||
                                 (store[i].voter == voter && store[i].stamp <= stamp)) begin
                        store.delete(i);
                    end else begin
                        if (store[i].voter == voter) keep_new = 0;
                        i++;
                    end
                end
                if (keep_new && store.size() < 64) begin
                    e.root = root;
                    e.block = blk;
                    e.voter = voter;
                    e.stamp = stamp;
                    store.push_back(e);
                end else begin
                    keep_new = 0;
                end
                push_beat(0, 0, 0, keep_new, 1);
            end
            vhc_pkg::KIND_ERASE: begin
                i = 0;
                while (i < store.size()) begin
                    if (store[i].root == root) store.delete(i);
                    else i++;
                end
                push_beat(0, 0, 0, 0, 1);
            end
            vhc_pkg::KIND_LOOKUP: begin
                n = 0;
                for (i = 0; i < store.size() && n < 64; i++) begin
                    hit = store[i].root == root;
                    if (hit && mb)
                        hit = store[i].block == blk &&
                              (!fo || store[i].stamp == vhc_pkg::FINAL_STAMP);
                    if (hit) begin
                        push_beat(1, store[i].voter, store[i].stamp, 0, 0);
                        n++;
                    end
                end
                if (n == 0) push_beat(0, 0, 0, 0, 1);
                else pending[pending.size() - 1].last = 1;
            end
            default: begin
                push_beat(0, 0, 0, 0, 1);
            end
        endcase
    endfunction

    function void check_beat(vote_beat_t got);
        vote_beat_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat");
            return;
        end
        want = pending.pop_front();
        if (got.found !== want.found || got.voter !== want.voter ||
            got.stamp !== want.stamp || got.stored !== want.stored ||
            got.occupancy !== want.occupancy || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp f%0b v%h s%h st%0b o%0d l%0b got f%0b v%h s%h st%0b o%0d l%0b",
                         want.found, want.voter, want.stamp, want.stored, want.occupancy,
                         want.last, got.found, got.voter, got.stamp, got.stored,
                         got.occupancy, got.last);
        end
    endfunction
endclass

module tb;
    import vhc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [63:0] s_root_tag;
    logic [63:0] s_block_tag;
    logic [63:0] s_voter;
    logic [63:0] s_stamp;
    logic        s_match_block;
    logic        s_final_only;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [63:0] m_out_voter;
    logic [63:0] m_out_stamp;
    logic        m_stored;
    logic [6:0]  m_occupancy;
    logic        m_last;

    vote_scoreboard votes;
    int unsigned    idle_cycles;
    bit             calm;
    bit             timed_out;
    logic [63:0]    roots [4];
    logic [63:0]    blocks [4];
    logic [63:0]    voters [6];

    vote_history_cache_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_root_tag(s_root_tag), .s_block_tag(s_block_tag), .s_voter(s_voter),
        .s_stamp(s_stamp), .s_match_block(s_match_block), .s_final_only(s_final_only),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_out_voter(m_out_voter), .m_out_stamp(m_out_stamp), .m_stored(m_stored),
        .m_occupancy(m_occupancy), .m_last(m_last)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_kind = '0;
        s_root_tag = '0;
        s_block_tag = '0;
        s_voter = '0;
        s_stamp = '0;
        s_match_block = 0;
        s_final_only = 0;
        cfg_valid = 0;
        cfg_data = '0;
        m_ready = 0;
        votes = new();
        calm = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 20);
            if (m_valid && m_ready) begin
                vote_beat_t b;
                b.found = m_found;
                b.voter = m_out_voter;
                b.stamp = m_out_stamp;
                b.stored = m_stored;
                b.occupancy = m_occupancy;
                b.last = m_last;
                votes.check_beat(b);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        timed_out = 0;
        wait (aresetn === 1'b1);
        wait (idle_cycles >= 5000);
        timed_out = 1;
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_cmd(kind_t kind, logic [63:0] root, logic [63:0] blk,
                            logic [63:0] voter, logic [63:0] stamp, logic mb, logic fo);
        while (!calm && $urandom_range(99) < 20) @(posedge aclk);
        s_valid <= 1;
        s_kind <= kind;
        s_root_tag <= root;
        s_block_tag <= blk;
        s_voter <= voter;
        s_stamp <= stamp;
        s_match_block <= mb;
        s_final_only <= fo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        votes.note_command(kind, root, blk, voter, stamp, mb, fo);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (votes.pending.size() != 0) @(posedge aclk);
        repeat (140) @(posedge aclk);
    endtask

    task automatic write_limit(logic [5:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        votes.set_limit(v);
        cfg_valid <= 0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_cmd();
        int unsigned r;
        logic [63:0] st;
        r = $urandom_range(99);
        st = ($urandom_range(9) == 0) ? FINAL_STAMP : 64'($urandom_range(7));
        if ($urandom_range(99) < 8) st = rnd64();
        if (r < 4)
            send_cmd(kind_t'($urandom_range(3)), rnd64(), rnd64(), rnd64(), rnd64(),
                     $urandom_range(1), $urandom_range(1));
        else if (r < 60)
            send_cmd(KIND_ADD, roots[$urandom_range(3)], blocks[$urandom_range(3)],
                     voters[$urandom_range(5)], st, $urandom_range(1), $urandom_range(1));
        else if (r < 68)
            send_cmd(KIND_ERASE, roots[$urandom_range(3)], rnd64(), rnd64(), rnd64(),
                     $urandom_range(1), $urandom_range(1));
        else
            send_cmd(KIND_LOOKUP, roots[$urandom_range(3)], blocks[$urandom_range(3)],
                     rnd64(), rnd64(), $urandom_range(1), $urandom_range(1));
    endtask

    initial begin
        for (int i = 0; i < 4; i++) roots[i] = rnd64();
        for (int i = 0; i < 4; i++) blocks[i] = rnd64();
        for (int i = 0; i < 6; i++) voters[i] = rnd64();
        roots[0] = '1;
        blocks[1] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_cmd(KIND_LOOKUP, '0, '0, '0, '0, 0, 0);
        send_cmd(KIND_ADD, '0, '0, '0, '0, 0, 0);
        send_cmd(KIND_ADD, '1, '1, '1, FINAL_STAMP, 1, 1);
        send_cmd(KIND_ADD, '1, '1, 64'd5, 64'd3, 0, 0);
        send_cmd(KIND_ADD, '1, '1, 64'd5, 64'd2, 0, 0);
        send_cmd(KIND_ADD, '1, '1, 64'd5, 64'd3, 0, 0);
        send_cmd(KIND_LOOKUP, '1, '1, '0, '0, 0, 1);
        send_cmd(KIND_LOOKUP, '1, '1, '0, '0, 1, 1);
        send_cmd(KIND_LOOKUP, '1, '1, '0, '0, 1, 0);
        send_cmd(KIND_LOOKUP, '1, '0, '0, '0, 1, 0);
        send_cmd(KIND_ADD, '1, 64'd7, 64'd9, 64'd1, 0, 0);
        send_cmd(KIND_NONE, '1, '1, '1, '1, 1, 1);
        send_cmd(KIND_ERASE, '1, '0, '0, '0, 0, 0);
        send_cmd(KIND_LOOKUP, '1, '0, '0, '0, 0, 0);
        for (int i = 0; i < 66; i++)
            send_cmd(KIND_ADD, 64'(i), 64'(i), 64'(i), 64'(i), 0, 0);
        send_cmd(KIND_LOOKUP, 64'd65, '0, '0, '0, 0, 0);
        write_limit(6'd0);
        send_cmd(KIND_ADD, '1, '1, '1, '1, 0, 0);
        send_cmd(KIND_ADD, '0, '1, '1, '1, 0, 0);
        write_limit(6'd63);

        for (int phase = 0; phase < 4; phase++) begin
            write_limit(phase == 0 ? 6'd1 : phase == 1 ? 6'($urandom_range(2, 40))
                        : phase == 2 ? 6'd63 : 6'd10);
            for (int i = 0; i < 95; i++) begin
                calm = (phase == 2 && i < 40);
                random_cmd();
                if (i == 50) begin
                    @(posedge aclk);
                    while (votes.pending.size() != 0) @(posedge aclk);
                end
            end
            calm = 0;
        end

        drain();
        if (votes.mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
rtl/vhc_pkg.sv
rtl/vhc_ram.sv
rtl/vhc_datapath.sv
rtl/vhc_ctrl.sv
rtl/vote_history_cache_top.sv
rtl/vhc_checker.sv
sim/tb.sv
